// ===== hdl/lkat_pkg.sv =====
// ----------------------------------------------------------------------------
// lkat_pkg
// Shared constants and fixed-point helpers for the look-at view matrix block.
// ----------------------------------------------------------------------------
package lkat_pkg;

	// fraction bits of every fixed-point value
	localparam int FRAC_BITS = 16;
	// unit vector component width, holds [-2^F, 2^F]
	localparam int UNIT_W    = FRAC_BITS + 2;
	// input vector component width
	localparam int VEC_W     = 32;
	// scaled magnitude width inside the normalizer, [2^29, 2^30)
	localparam int SCL_W     = 30;
	// square root width of a sum of three SCL_W squares
	localparam int ROOT_W    = SCL_W + 1;
	// quotient bits of one normalized component
	localparam int QUO_W     = FRAC_BITS + 1;
	// normalizer stages in order: max, lead one, scale, square, sum, root, prep, divide, sign
	localparam int NORM_LAT  = 5 + ROOT_W + 1 + QUO_W + 1;

	// Shift right by FRAC_BITS, rounding half away from zero.
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x);
		logic [63:0] m;
		m = x[63] ? (~x + 64'd1) : x;
		m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x[63] ? -$signed(m) : $signed(m);
	endfunction

	// Clamp to magnitude 2^FRAC_BITS.
	function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [63:0] x);
		logic signed [63:0] one;
		one = 64'sd1 <<< FRAC_BITS;
		if (x > one)
			return UNIT_W'(one);
		else if (x < -one)
			return UNIT_W'(-one);
		else
			return UNIT_W'(x);
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

endpackage

// ===== hdl/lkat_norm.sv =====
// ----------------------------------------------------------------------------
// lkat_norm
// Pipelined 3-vector normalizer: power-of-two scaling, digit-serial square
// root and restoring division, one stage per result bit.
// ----------------------------------------------------------------------------
module lkat_norm
	import lkat_pkg::*;
#(
	parameter int IN_W = 33,
	parameter int SB_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [2:0][IN_W-1:0]         in_v,
	input  logic [SB_W-1:0]              in_sb,
	output logic                         out_vld,
	output logic [2:0][UNIT_W-1:0]       out_r,
	output logic                         out_zero,
	output logic [SB_W-1:0]              out_sb
);

	localparam int EW = (IN_W > SCL_W) ? IN_W : SCL_W;
	localparam int PW = $clog2(EW) + 1;
	localparam int SQ_W = 2 * SCL_W;
	localparam int SUM_W = 2 * ROOT_W;
	localparam int RW = ROOT_W + 4;
	localparam int NW = SCL_W + FRAC_BITS + 1;
	localparam int TOP_BIT = SCL_W - 1;

	// stage a: magnitudes, signs, largest magnitude
	logic [IN_W-1:0] mag_n [3];
	logic [IN_W-1:0] mx_n;
	logic [IN_W-1:0] mag_s1 [3];
	logic [IN_W-1:0] mx_s1;
	logic [2:0]      sg_s1;
	logic [SB_W-1:0] sb_s1;
	logic            vld_s1;

	always_comb begin
		mx_n = '0;
		for (int i = 0; i < 3; i++) begin
			mag_n[i] = in_v[i][IN_W-1] ? (~in_v[i] + IN_W'(1)) : in_v[i];
			if (mag_n[i] > mx_n)
				mx_n = mag_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_n[i];
			sg_s1[i]  <= in_v[i][IN_W-1];
		end
		mx_s1 <= mx_n;
		sb_s1 <= in_sb;
	end

	// stage b: leading one of the largest magnitude
	logic [PW-1:0]   p_n;
	logic [PW-1:0]   p_s2;
	logic [IN_W-1:0] mag_s2 [3];
	logic [2:0]      sg_s2;
	logic            z_s2;
	logic [SB_W-1:0] sb_s2;
	logic            vld_s2;

	always_comb begin
		p_n = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (mx_s1[b])
				p_n = PW'(b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		p_s2   <= p_n;
		mag_s2 <= mag_s1;
		sg_s2  <= sg_s1;
		z_s2   <= (mx_s1 == '0);
		sb_s2  <= sb_s1;
	end

	// stage c: scale so the largest magnitude lands in [2^29, 2^30)
	logic [SCL_W-1:0] c_n [3];
	logic [SCL_W-1:0] c_s3 [3];
	logic [2:0]       sg_s3;
	logic             z_s3;
	logic [SB_W-1:0]  sb_s3;
	logic             vld_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (p_s2 >= PW'(TOP_BIT))
				c_n[i] = SCL_W'(EW'(mag_s2[i]) >> (p_s2 - PW'(TOP_BIT)));
			else
				c_n[i] = SCL_W'(EW'(mag_s2[i]) << (PW'(TOP_BIT) - p_s2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		c_s3  <= c_n;
		sg_s3 <= sg_s2;
		z_s3  <= z_s2;
		sb_s3 <= sb_s2;
	end

	// stage d: squares
	logic [SQ_W-1:0]  sq_s4 [3];
	logic [SCL_W-1:0] c_s4 [3];
	logic [2:0]       sg_s4;
	logic             z_s4;
	logic [SB_W-1:0]  sb_s4;
	logic             vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			sq_s4[i] <= SQ_W'(c_s3[i]) * SQ_W'(c_s3[i]);
		c_s4  <= c_s3;
		sg_s4 <= sg_s3;
		z_s4  <= z_s3;
		sb_s4 <= sb_s3;
	end

	// square root pipeline, index 0 is the sum of squares
	logic [SUM_W-1:0]  x_s   [0:ROOT_W];
	logic [RW-1:0]     rem_s [0:ROOT_W];
	logic [ROOT_W-1:0] rt_s  [0:ROOT_W];
	logic [SCL_W-1:0]  cr_s  [0:ROOT_W][3];
	logic [2:0]        sgr_s [0:ROOT_W];
	logic              zr_s  [0:ROOT_W];
	logic [SB_W-1:0]   sbr_s [0:ROOT_W];
	logic              vr_s  [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vr_s[0] <= 1'b0;
		else
			vr_s[0] <= vld_s4;
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		rem_s[0] <= '0;
		rt_s[0]  <= '0;
		cr_s[0]  <= c_s4;
		sgr_s[0] <= sg_s4;
		zr_s[0]  <= z_s4;
		sbr_s[0] <= sb_s4;
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		localparam int HI = 2 * (ROOT_W - 1 - k) + 1;
		logic [RW-1:0] r2;
		logic [RW-1:0] tr;
		logic          take;

		// one root bit per stage
		assign r2   = {rem_s[k][RW-3:0], x_s[k][HI -: 2]};
		assign tr   = RW'({rt_s[k], 2'b01});
		assign take = (r2 >= tr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vr_s[k+1] <= 1'b0;
			else
				vr_s[k+1] <= vr_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? (r2 - tr) : r2;
			rt_s[k+1]  <= {rt_s[k][ROOT_W-2:0], take};
			x_s[k+1]   <= x_s[k];
			cr_s[k+1]  <= cr_s[k];
			sgr_s[k+1] <= sgr_s[k];
			zr_s[k+1]  <= zr_s[k];
			sbr_s[k+1] <= sbr_s[k];
		end
	end

	// division pipeline, index 0 holds rounded numerators
	logic [NW-1:0]     rd_s  [0:QUO_W][3];
	logic [QUO_W-1:0]  q_s   [0:QUO_W][3];
	logic [ROOT_W-1:0] len_s [0:QUO_W];
	logic [2:0]        sgd_s [0:QUO_W];
	logic              zd_s  [0:QUO_W];
	logic [SB_W-1:0]   sbd_s [0:QUO_W];
	logic              vd_s  [0:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vd_s[0] <= 1'b0;
		else
			vd_s[0] <= vr_s[ROOT_W];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rd_s[0][i] <= NW'({cr_s[ROOT_W][i], FRAC_BITS'(0)})
				+ NW'(rt_s[ROOT_W] >> 1);
			q_s[0][i]  <= '0;
		end
		len_s[0] <= rt_s[ROOT_W];
		sgd_s[0] <= sgr_s[ROOT_W];
		zd_s[0]  <= zr_s[ROOT_W];
		sbd_s[0] <= sbr_s[ROOT_W];
	end

	for (genvar t = 0; t < QUO_W; t++) begin : g_div
		localparam int J = QUO_W - 1 - t;
		logic [NW-1:0] dv;

		// one quotient bit per stage, three lanes
		assign dv = NW'(len_s[t]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vd_s[t+1] <= 1'b0;
			else
				vd_s[t+1] <= vd_s[t];
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rd_s[t][i] >= dv) begin
					rd_s[t+1][i] <= rd_s[t][i] - dv;
					q_s[t+1][i]  <= {q_s[t][i][QUO_W-2:0], 1'b1};
				end else begin
					rd_s[t+1][i] <= rd_s[t][i];
					q_s[t+1][i]  <= {q_s[t][i][QUO_W-2:0], 1'b0};
				end
			end
			len_s[t+1] <= len_s[t];
			sgd_s[t+1] <= sgd_s[t];
			zd_s[t+1]  <= zd_s[t];
			sbd_s[t+1] <= sbd_s[t];
		end
	end

	// final stage: clamp to one and restore sign
	logic [UNIT_W-1:0] qm [3];
	logic [UNIT_W-1:0] one_u;

	assign one_u = UNIT_W'(1) << FRAC_BITS;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qm[i] = UNIT_W'(q_s[QUO_W][i]);
			if (qm[i] > one_u)
				qm[i] = one_u;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= vd_s[QUO_W];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			out_r[i] <= sgd_s[QUO_W][i] ? (~qm[i] + UNIT_W'(1)) : qm[i];
		out_zero <= zd_s[QUO_W];
		out_sb   <= sbd_s[QUO_W];
	end

endmodule

// ===== hdl/look_at_view_matrix.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Camera view matrix setup: forward, side and up rows plus translations.
// ----------------------------------------------------------------------------
// A new camera may be started in every cycle; busy stays low. Each start
// produces one result, marked by done for one cycle, after passing through
// one input stage, two normalizers of 55 stages each (31 square-root stages
// and 17 divider stages dominate), two cross-product stages and six stages
// for the up vector and translations. The receiver cannot stall, so results
// leave in start order with no buffering. A zero direction, or an up vector
// parallel to it, gives an all-zero result.
module look_at_view_matrix
	import lkat_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     op,
	input  logic signed [VEC_W-1:0]  pos_x,
	input  logic signed [VEC_W-1:0]  pos_y,
	input  logic signed [VEC_W-1:0]  pos_z,
	input  logic signed [VEC_W-1:0]  dir_x,
	input  logic signed [VEC_W-1:0]  dir_y,
	input  logic signed [VEC_W-1:0]  dir_z,
	input  logic signed [VEC_W-1:0]  up_x,
	input  logic signed [VEC_W-1:0]  up_y,
	input  logic signed [VEC_W-1:0]  up_z,
	output logic                     done,
	output logic signed [UNIT_W-1:0] side_x,
	output logic signed [UNIT_W-1:0] side_y,
	output logic signed [UNIT_W-1:0] side_z,
	output logic signed [UNIT_W-1:0] upv_x,
	output logic signed [UNIT_W-1:0] upv_y,
	output logic signed [UNIT_W-1:0] upv_z,
	output logic signed [UNIT_W-1:0] fwd_x,
	output logic signed [UNIT_W-1:0] fwd_y,
	output logic signed [UNIT_W-1:0] fwd_z,
	output logic signed [31:0]       trans_x,
	output logic signed [31:0]       trans_y,
	output logic signed [31:0]       trans_z
);

	localparam int D_W  = VEC_W + 1;
	localparam int XP_W = UNIT_W + VEC_W;
	localparam int XC_W = XP_W + 1;
	localparam int UP_W = 2 * UNIT_W;
	localparam int UC_W = UP_W + 1;
	localparam int DT_W = XP_W + 2;
	localparam int P3_W = 3 * VEC_W;
	localparam int F3_W = 3 * UNIT_W;
	localparam int SB1_W = 2 * P3_W;
	localparam int SB2_W = 1 + F3_W + P3_W;

	assign busy = 1'b0;

	// input stage: direction, or target minus position
	logic [2:0][D_W-1:0]   d_s1;
	logic [2:0][VEC_W-1:0] pos_s1;
	logic [2:0][VEC_W-1:0] up_s1;
	logic                  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (op) begin
			d_s1[0] <= D_W'(dir_x) - D_W'(pos_x);
			d_s1[1] <= D_W'(dir_y) - D_W'(pos_y);
			d_s1[2] <= D_W'(dir_z) - D_W'(pos_z);
		end else begin
			d_s1[0] <= D_W'(dir_x);
			d_s1[1] <= D_W'(dir_y);
			d_s1[2] <= D_W'(dir_z);
		end
		pos_s1 <= {pos_z, pos_y, pos_x};
		up_s1  <= {up_z, up_y, up_x};
	end

	// forward vector
	logic                   n1_vld;
	logic [2:0][UNIT_W-1:0] n1_f;
	logic                   n1_zero;
	logic [SB1_W-1:0]       n1_sb;

	lkat_norm #(
		.IN_W (D_W),
		.SB_W (SB1_W)
	) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_v     (d_s1),
		.in_sb    ({pos_s1, up_s1}),
		.out_vld  (n1_vld),
		.out_r    (n1_f),
		.out_zero (n1_zero),
		.out_sb   (n1_sb)
	);

	logic [2:0][VEC_W-1:0] n1_pos;
	logic [2:0][VEC_W-1:0] n1_up;

	assign {n1_pos, n1_up} = n1_sb;

	// cross(f, up): products then differences
	logic signed [XP_W-1:0] xp_s2 [6];
	logic [2:0][UNIT_W-1:0] f_s2;
	logic [2:0][VEC_W-1:0]  pos_s2;
	logic                   z_s2;
	logic                   vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= n1_vld;
	end

	always_ff @(posedge clk) begin
		xp_s2[0] <= $signed(n1_f[1]) * $signed(n1_up[2]);
		xp_s2[1] <= $signed(n1_f[2]) * $signed(n1_up[1]);
		xp_s2[2] <= $signed(n1_f[2]) * $signed(n1_up[0]);
		xp_s2[3] <= $signed(n1_f[0]) * $signed(n1_up[2]);
		xp_s2[4] <= $signed(n1_f[0]) * $signed(n1_up[1]);
		xp_s2[5] <= $signed(n1_f[1]) * $signed(n1_up[0]);
		f_s2     <= n1_f;
		pos_s2   <= n1_pos;
		z_s2     <= n1_zero;
	end

	logic [2:0][XC_W-1:0]   xc_s3;
	logic [2:0][UNIT_W-1:0] f_s3;
	logic [2:0][VEC_W-1:0]  pos_s3;
	logic                   z_s3;
	logic                   vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		xc_s3[0] <= XC_W'(xp_s2[0]) - XC_W'(xp_s2[1]);
		xc_s3[1] <= XC_W'(xp_s2[2]) - XC_W'(xp_s2[3]);
		xc_s3[2] <= XC_W'(xp_s2[4]) - XC_W'(xp_s2[5]);
		f_s3     <= f_s2;
		pos_s3   <= pos_s2;
		z_s3     <= z_s2;
	end

	// side vector
	logic                   n2_vld;
	logic [2:0][UNIT_W-1:0] n2_s;
	logic                   n2_zero;
	logic [SB2_W-1:0]       n2_sb;

	lkat_norm #(
		.IN_W (XC_W),
		.SB_W (SB2_W)
	) u_norm_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_v     (xc_s3),
		.in_sb    ({z_s3, f_s3, pos_s3}),
		.out_vld  (n2_vld),
		.out_r    (n2_s),
		.out_zero (n2_zero),
		.out_sb   (n2_sb)
	);

	logic                   n2_z1;
	logic [2:0][UNIT_W-1:0] n2_f;
	logic [2:0][VEC_W-1:0]  n2_pos;

	assign {n2_z1, n2_f, n2_pos} = n2_sb;

	// p1: cross(f, s) products and dot products with position
	logic signed [UP_W-1:0] up_s4 [6];
	logic signed [XP_W-1:0] sp_s4 [3];
	logic signed [XP_W-1:0] fp_s4 [3];
	logic [2:0][UNIT_W-1:0] s_s4;
	logic [2:0][UNIT_W-1:0] f_s4;
	logic [2:0][VEC_W-1:0]  pos_s4;
	logic                   z_s4;
	logic                   vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= n2_vld;
	end

	always_ff @(posedge clk) begin
		up_s4[0] <= $signed(n2_f[1]) * $signed(n2_s[2]);
		up_s4[1] <= $signed(n2_f[2]) * $signed(n2_s[1]);
		up_s4[2] <= $signed(n2_f[2]) * $signed(n2_s[0]);
		up_s4[3] <= $signed(n2_f[0]) * $signed(n2_s[2]);
		up_s4[4] <= $signed(n2_f[0]) * $signed(n2_s[1]);
		up_s4[5] <= $signed(n2_f[1]) * $signed(n2_s[0]);
		for (int i = 0; i < 3; i++) begin
			sp_s4[i] <= $signed(n2_s[i]) * $signed(n2_pos[i]);
			fp_s4[i] <= $signed(n2_f[i]) * $signed(n2_pos[i]);
		end
		s_s4   <= n2_s;
		f_s4   <= n2_f;
		pos_s4 <= n2_pos;
		z_s4   <= n2_z1 || n2_zero;
	end

	// p2: cross differences and dot sums
	logic signed [UC_W-1:0] uc_s5 [3];
	logic signed [DT_W-1:0] ds_s5;
	logic signed [DT_W-1:0] df_s5;
	logic [2:0][UNIT_W-1:0] s_s5;
	logic [2:0][UNIT_W-1:0] f_s5;
	logic [2:0][VEC_W-1:0]  pos_s5;
	logic                   z_s5;
	logic                   vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		uc_s5[0] <= UC_W'(up_s4[0]) - UC_W'(up_s4[1]);
		uc_s5[1] <= UC_W'(up_s4[2]) - UC_W'(up_s4[3]);
		uc_s5[2] <= UC_W'(up_s4[4]) - UC_W'(up_s4[5]);
		ds_s5    <= DT_W'(sp_s4[0]) + DT_W'(sp_s4[1]) + DT_W'(sp_s4[2]);
		df_s5    <= DT_W'(fp_s4[0]) + DT_W'(fp_s4[1]) + DT_W'(fp_s4[2]);
		s_s5     <= s_s4;
		f_s5     <= f_s4;
		pos_s5   <= pos_s4;
		z_s5     <= z_s4;
	end

	// p3: round the up vector, side and forward translations
	logic [2:0][UNIT_W-1:0] u_s6;
	logic signed [31:0]     ts_s6;
	logic signed [31:0]     tf_s6;
	logic [2:0][UNIT_W-1:0] s_s6;
	logic [2:0][UNIT_W-1:0] f_s6;
	logic [2:0][VEC_W-1:0]  pos_s6;
	logic                   z_s6;
	logic                   vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			u_s6[i] <= clamp_unit(rnd_shr(64'(uc_s5[i])));
		ts_s6  <= sat32(-rnd_shr(64'(ds_s5)));
		tf_s6  <= sat32(-rnd_shr(64'(df_s5)));
		s_s6   <= s_s5;
		f_s6   <= f_s5;
		pos_s6 <= pos_s5;
		z_s6   <= z_s5;
	end

	// p4: up vector times position
	logic signed [XP_W-1:0] upp_s7 [3];
	logic [2:0][UNIT_W-1:0] u_s7;
	logic signed [31:0]     ts_s7;
	logic signed [31:0]     tf_s7;
	logic [2:0][UNIT_W-1:0] s_s7;
	logic [2:0][UNIT_W-1:0] f_s7;
	logic                   z_s7;
	logic                   vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else
			vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			upp_s7[i] <= $signed(u_s6[i]) * $signed(pos_s6[i]);
		u_s7  <= u_s6;
		ts_s7 <= ts_s6;
		tf_s7 <= tf_s6;
		s_s7  <= s_s6;
		f_s7  <= f_s6;
		z_s7  <= z_s6;
	end

	// p5: up dot sum
	logic signed [DT_W-1:0] du_s8;
	logic [2:0][UNIT_W-1:0] u_s8;
	logic signed [31:0]     ts_s8;
	logic signed [31:0]     tf_s8;
	logic [2:0][UNIT_W-1:0] s_s8;
	logic [2:0][UNIT_W-1:0] f_s8;
	logic                   z_s8;
	logic                   vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s8 <= 1'b0;
		else
			vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		du_s8 <= DT_W'(upp_s7[0]) + DT_W'(upp_s7[1]) + DT_W'(upp_s7[2]);
		u_s8  <= u_s7;
		ts_s8 <= ts_s7;
		tf_s8 <= tf_s7;
		s_s8  <= s_s7;
		f_s8  <= f_s7;
		z_s8  <= z_s7;
	end

	// p6: output register, degenerate inputs give all zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_s8;
	end

	always_ff @(posedge clk) begin
		if (z_s8) begin
			side_x  <= '0;
			side_y  <= '0;
			side_z  <= '0;
			upv_x   <= '0;
			upv_y   <= '0;
			upv_z   <= '0;
			fwd_x   <= '0;
			fwd_y   <= '0;
			fwd_z   <= '0;
			trans_x <= '0;
			trans_y <= '0;
			trans_z <= '0;
		end else begin
			side_x  <= s_s8[0];
			side_y  <= s_s8[1];
			side_z  <= s_s8[2];
			upv_x   <= u_s8[0];
			upv_y   <= u_s8[1];
			upv_z   <= u_s8[2];
			fwd_x   <= f_s8[0];
			fwd_y   <= f_s8[1];
			fwd_z   <= f_s8[2];
			trans_x <= ts_s8;
			trans_y <= sat32(-rnd_shr(64'(du_s8)));
			trans_z <= tf_s8;
		end
	end

	// checks
	localparam logic signed [UNIT_W-1:0] ONE_U = UNIT_W'(1) << FRAC_BITS;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_side_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (side_x <= ONE_U) && (side_x >= -ONE_U) && (fwd_z <= ONE_U)
			&& (fwd_z >= -ONE_U))
		else $error("unit component out of range");

	a_zero_all: assert property (@(posedge clk) disable iff (!arst_n)
		done && (fwd_x == '0) && (fwd_y == '0) && (fwd_z == '0)
			|-> (side_x == '0) && (upv_y == '0) && (trans_x == '0)
			&& (trans_y == '0) && (trans_z == '0))
		else $error("zero forward with nonzero result");

	a_done_chain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |=> done)
		else $error("result strobe lost");

endmodule

// ===== dv/tb_look_at_view_matrix.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// Self-checking bench for the look-at view matrix block. A queue of camera
// setups (directed corner cases, then random ones) feeds a clocked driver
// with random idle bursts. Each transfer is predicted in place and the
// expected rows and translations are matched field by field, in order,
// against every done strobe.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix
	import lkat_pkg::*;
();

	typedef logic signed [VEC_W-1:0] comp_t;

	typedef struct {
		logic  op;
		comp_t pos [3];
		comp_t dir [3];
		comp_t up  [3];
		bit    drain;     // hold off until every pending result is back
	} camera_t;

	typedef struct {
		logic signed [UNIT_W-1:0] unit [9];  // side, up, forward
		logic signed [31:0]       tr   [3];
	} view_t;

	typedef longint vec3_t [3];

	localparam int ONE        = 1 << FRAC_BITS;
	localparam int WDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start;
	logic busy, done;
	logic signed [UNIT_W-1:0] side_x, side_y, side_z, upv_x, upv_y, upv_z;
	logic signed [UNIT_W-1:0] fwd_x, fwd_y, fwd_z;
	logic signed [31:0] trans_x, trans_y, trans_z;

	camera_t cur_cam;
	camera_t pending_cams [$];
	view_t   view_q [$];
	int      idle_left = 0;
	int      err_cnt = 0;
	int      wdog = 0;

	// clock
	always #5 clk = ~clk;

	look_at_view_matrix u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(cur_cam.op),
		.pos_x(cur_cam.pos[0]), .pos_y(cur_cam.pos[1]), .pos_z(cur_cam.pos[2]),
		.dir_x(cur_cam.dir[0]), .dir_y(cur_cam.dir[1]), .dir_z(cur_cam.dir[2]),
		.up_x(cur_cam.up[0]), .up_y(cur_cam.up[1]), .up_z(cur_cam.up[2]),
		.done(done),
		.side_x(side_x), .side_y(side_y), .side_z(side_z),
		.upv_x(upv_x), .upv_y(upv_y), .upv_z(upv_z),
		.fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
		.trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z)
	);

	// ---------------------------------------------------------------- predictor
	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint to_unit(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	// shift out the fraction, rounding half away from zero
	function automatic longint drop_frac(longint x);
		longint unsigned m;
		m = (mag(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	// scale so the largest magnitude sits in [2^29, 2^30), then divide by length
	function automatic bit unit_vec(input vec3_t v, output vec3_t r);
		vec3_t c;
		longint unsigned mx = 0, sum = 0, len, q;
		int k = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = v[i];
			r[i] = 0;
			if (mag(v[i]) > mx) mx = mag(v[i]);
		end
		if (mx == 0) return 1'b0;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			k++;
		end
		if (k > 0)
			for (int i = 0; i < 3; i++) c[i] = c[i] / (longint'(1) << k);
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) c[i] = c[i] * 2;
		end
		for (int i = 0; i < 3; i++) sum += mag(c[i]) * mag(c[i]);
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag(c[i]) << FRAC_BITS) + (len >> 1)) / len;
			r[i] = to_unit(c[i] < 0 ? -longint'(q) : longint'(q));
		end
		return 1'b1;
	endfunction

	function automatic vec3_t cross3(vec3_t a, vec3_t b);
		vec3_t r;
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
		return r;
	endfunction

	function automatic logic signed [31:0] shift_of(vec3_t a, vec3_t p);
		longint t;
		t = -drop_frac(a[0] * p[0] + a[1] * p[1] + a[2] * p[2]);
		if (t > 64'sd2147483647) return 32'sh7fffffff;
		if (t < -64'sd2147483648) return 32'sh80000000;
		return t[31:0];
	endfunction

	function automatic view_t predict_view(camera_t cam);
		view_t  res;
		vec3_t  p, d, upv, f, sc, s, uc, u;
		for (int i = 0; i < 9; i++) res.unit[i] = '0;
		for (int i = 0; i < 3; i++) begin
			res.tr[i] = '0;
			p[i] = cam.pos[i];
			d[i] = cam.dir[i];
			upv[i] = cam.up[i];
			if (cam.op) d[i] -= p[i];
		end
		if (!unit_vec(d, f)) return res;
		sc = cross3(f, upv);
		if (!unit_vec(sc, s)) return res;
		uc = cross3(f, s);
		for (int i = 0; i < 3; i++) begin
			u[i] = to_unit(drop_frac(uc[i]));
			res.unit[i] = s[i][UNIT_W-1:0];
			res.unit[3+i] = u[i][UNIT_W-1:0];
			res.unit[6+i] = f[i][UNIT_W-1:0];
		end
		res.tr[0] = shift_of(s, p);
		res.tr[1] = shift_of(u, p);
		res.tr[2] = shift_of(f, p);
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic comp_t rand_comp();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? comp_t'($urandom_range(0, 1 << 17))
				: -comp_t'($urandom_range(0, 1 << 17));
			2: case ($urandom_range(0, 4))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sd1;
				3: return -32'sd1;
				default: return '0;
			endcase
			default: return $urandom_range(0, 1) ? comp_t'($urandom_range(0, 1 << 24))
				: -comp_t'($urandom_range(0, 1 << 24));
		endcase
	endfunction

	function automatic comp_t small_comp();
		return comp_t'($urandom_range(0, 8192)) - 32'sd4096;
	endfunction

	function automatic camera_t mk_cam(logic o, comp_t px, comp_t py, comp_t pz,
		comp_t dx, comp_t dy, comp_t dz, comp_t ux, comp_t uy, comp_t uz);
		camera_t c;
		c.op = o;
		c.pos = '{px, py, pz};
		c.dir = '{dx, dy, dz};
		c.up = '{ux, uy, uz};
		c.drain = 1'b0;
		return c;
	endfunction

	function automatic camera_t rand_cam();
		camera_t c;
		comp_t   v [3];
		int      m;
		c.op = $urandom_range(0, 1);
		c.drain = 1'b0;
		for (int i = 0; i < 3; i++) begin
			c.pos[i] = rand_comp();
			c.dir[i] = rand_comp();
			c.up[i] = rand_comp();
		end
		case ($urandom_range(0, 9))
			// up along the forward direction
			0, 1: begin
				m = $urandom_range(0, 8) - 4;
				for (int i = 0; i < 3; i++) begin
					v[i] = small_comp();
					c.pos[i] = small_comp();
					c.dir[i] = c.op ? c.pos[i] + v[i] : v[i];
					c.up[i] = v[i] * m;
				end
			end
			// no direction at all
			2: for (int i = 0; i < 3; i++) c.dir[i] = c.op ? c.pos[i] : '0;
			default: ;
		endcase
		return c;
	endfunction

	// ---------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		camera_t nxt;
		logic    go;
		if (!arst_n) begin
			start <= 1'b0;
			cur_cam <= mk_cam(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		end else begin
			go = start && busy;
			nxt = cur_cam;
			if (start && !busy)
				view_q.push_back(predict_view(cur_cam));
			if (!(start && busy)) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_cams.size() != 0) begin
					if (pending_cams[0].drain && view_q.size() != 0) begin
						go = 1'b0;
					end else begin
						nxt = pending_cams.pop_front();
						go = 1'b1;
						if (pending_cams.size() > 120 && $urandom_range(0, 11) == 0)
							idle_left = $urandom_range(1, 19);
					end
				end
			end
			start <= go;
			cur_cam <= nxt;
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		view_t got, want;
		if (arst_n && done) begin
			got.unit = '{side_x, side_y, side_z, upv_x, upv_y, upv_z, fwd_x, fwd_y, fwd_z};
			got.tr = '{trans_x, trans_y, trans_z};
			if (view_q.size() == 0) begin
				$error("result with no camera outstanding");
				err_cnt++;
			end else begin
				want = view_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got.unit[i] !== want.unit[i]) begin
						$error("%s_%s exp %0d got %0d",
							i < 3 ? "side" : (i < 6 ? "upv" : "fwd"),
							i % 3 == 0 ? "x" : (i % 3 == 1 ? "y" : "z"),
							want.unit[i], got.unit[i]);
						err_cnt++;
					end
				for (int i = 0; i < 3; i++)
					if (got.tr[i] !== want.tr[i]) begin
						$error("trans_%s exp %0d got %0d",
							i == 0 ? "x" : (i == 1 ? "y" : "z"), want.tr[i], got.tr[i]);
						err_cnt++;
					end
			end
		end
	end

	// watchdog: cycles without any transfer or result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		camera_t c;
		// basic views, both modes
		pending_cams.push_back(mk_cam(0, 0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
		pending_cams.push_back(mk_cam(1, ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, ONE, 0));
		pending_cams.push_back(mk_cam(0, 5*ONE, -7*ONE, ONE, 3, 4, 12, 0, 0, ONE));
		// zero direction, and target on the camera
		pending_cams.push_back(mk_cam(0, ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0));
		pending_cams.push_back(mk_cam(1, 32'sh80000000, 32'sh7fffffff, 5, 32'sh80000000,
			32'sh7fffffff, 5, 0, ONE, 0));
		// up parallel to forward, up zero
		pending_cams.push_back(mk_cam(0, 0, 0, 0, 0, ONE, 0, 0, 3*ONE, 0));
		pending_cams.push_back(mk_cam(0, 0, 0, 0, 0, ONE, 0, 0, -ONE, 0));
		pending_cams.push_back(mk_cam(1, 1, 2, 3, 2, 4, 6, 0, 0, 0));
		// field extremes
		pending_cams.push_back(mk_cam(0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1));
		pending_cams.push_back(mk_cam(1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 1, -1, 1));
		pending_cams.push_back(mk_cam(1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -1, -1, 32'sh7fffffff));
		pending_cams.push_back(mk_cam(0, -1, -1, -1, 1, 0, 0, 0, 1, 0));
		pending_cams.push_back(mk_cam(0, 32'shffffffff, 0, 32'sh55555555, -1, -1, -1,
			32'shaaaaaaaa, 32'sh55555555, 32'shffffffff));
		// translations that saturate
		pending_cams.push_back(mk_cam(0, 32'sh80000000, 0, 0, ONE, 0, 0, 0, ONE, 0));
		pending_cams.push_back(mk_cam(0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			ONE, ONE, ONE, 0, ONE, 0));
		pending_cams.push_back(mk_cam(0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			-ONE, -ONE, -ONE, ONE, 0, 0));
		// tiny vectors, scaled up inside the normalizer
		pending_cams.push_back(mk_cam(0, 0, 0, 0, 1, 1, 0, 0, 0, 1));
		pending_cams.push_back(mk_cam(1, 0, 0, 0, 0, 0, -1, -1, 0, 0));
		for (int n = 0; n < 850; n++) begin
			c = rand_cam();
			c.drain = (n == 5 || n == 400);
			pending_cams.push_back(c);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last transfer and its result, then keep watching for stray results
		while (pending_cams.size() != 0 || start || view_q.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);

		if (err_cnt == 0 && view_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lkat_pkg.sv
hdl/lkat_norm.sv
hdl/look_at_view_matrix.sv
dv/tb_look_at_view_matrix.sv
